// ===== sv/itda_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the decimal text converter.
// Used by itda_bin2bcd, itda_emit and int_to_decimal_ascii.
package itda_pkg;

    localparam int ITDA_VALUE_BITS = 32;
    localparam int ITDA_CODE_BITS  = 6;

    localparam logic [ITDA_CODE_BITS-1:0] ITDA_ASCII_ZERO  = 6'd48;
    localparam logic [ITDA_CODE_BITS-1:0] ITDA_ASCII_MINUS = 6'd45;
    localparam logic [3:0]                ITDA_RADIX_M1    = 4'd9;

    // decimal digits needed for an unsigned word of the given width
    function automatic int itda_ndig(input int bits);
        return (bits * 1233) / 4096 + 1;
    endfunction

    typedef enum logic [1:0] {
        C_IDLE,
        C_SHIFT,
        C_HOLD
    } t_conv_state;

    typedef enum logic [1:0] {
        E_IDLE,
        E_SKIP,
        E_SIGN,
        E_DIGIT
    } t_emit_state;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_bcd_ctl;

endpackage

// ===== sv/itda_bin2bcd.sv =====
`timescale 1ns / 1ps
// Bit-serial binary to BCD converter (shift and add 3), one input bit per cycle.
// Depends on itda_pkg.
module itda_bin2bcd #(
    parameter int VALUE_BITS = itda_pkg::ITDA_VALUE_BITS
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    output logic                                            o_ready,
    input  logic signed [VALUE_BITS-1:0]                    i_value,
    output itda_pkg::t_bcd_ctl                              o_ctl,
    output logic [4*itda_pkg::itda_ndig(VALUE_BITS)-1:0]    o_bcd,
    input  logic                                            i_ready
);
    import itda_pkg::*;

    localparam int NDIG = itda_ndig(VALUE_BITS);
    localparam int BW   = 4 * NDIG;
    localparam int CW   = $clog2(VALUE_BITS);
    localparam logic [CW-1:0] LAST_CNT = CW'(VALUE_BITS - 1);

    t_conv_state            r_state, n_state;
    logic [VALUE_BITS-1:0]  r_bin;
    logic [BW-1:0]          r_bcd;
    logic [BW-1:0]          w_adj;
    logic [CW-1:0]          r_cnt;
    logic                   r_neg;
    logic [VALUE_BITS-1:0]  w_mag;
    logic                   w_load;
    logic                   w_shift;
    logic                   w_out_valid;
    logic                   w_bcd_ok;

    assign w_mag = i_value[VALUE_BITS-1] ? VALUE_BITS'(~i_value + VALUE_BITS'(1))
                                         : i_value;

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            w_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                        : r_bcd[4*d +: 4];
        end
    end

    always_comb begin
        w_bcd_ok = 1'b1;
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[4*d +: 4] > ITDA_RADIX_M1) begin
                w_bcd_ok = 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (i_valid) begin
                    n_state = C_SHIFT;
                end
            end
            C_SHIFT: begin
                if (r_cnt == LAST_CNT) begin
                    n_state = C_HOLD;
                end
            end
            C_HOLD: begin
                if (i_ready) begin
                    n_state = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        w_out_valid = 1'b0;
        w_shift     = 1'b0;
        unique case (r_state)
            C_IDLE:  o_ready     = 1'b1;
            C_SHIFT: w_shift     = 1'b1;
            C_HOLD:  w_out_valid = 1'b1;
            default: o_ready     = 1'b0;
        endcase
    end

    assign w_load = i_valid && o_ready;
    assign o_ctl  = '{valid: w_out_valid, neg: r_neg};
    assign o_bcd  = r_bcd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bin <= w_mag;
            r_bcd <= '0;
            r_neg <= i_value[VALUE_BITS-1];
            r_cnt <= '0;
        end else if (w_shift) begin
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
            r_bcd <= {w_adj[BW-2:0], r_bin[VALUE_BITS-1]};
            r_cnt <= r_cnt + CW'(1);
        end
    end

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_state == C_SHIFT)
        else $error("accepted transfer did not start conversion");

    a_bcd_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == C_HOLD |-> w_bcd_ok)
        else $error("converted digit out of decimal range");

    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.valid && !i_ready) |=> o_ctl.valid && $stable(o_bcd) && $stable(r_neg))
        else $error("converted result changed while waiting");

endmodule

// ===== sv/itda_emit.sv =====
`timescale 1ns / 1ps
// Character emitter: drops leading zero digits, then sends sign and digits.
// Depends on itda_pkg.
module itda_emit #(
    parameter int VALUE_BITS = itda_pkg::ITDA_VALUE_BITS
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  itda_pkg::t_bcd_ctl                              i_ctl,
    input  logic [4*itda_pkg::itda_ndig(VALUE_BITS)-1:0]    i_bcd,
    output logic                                            o_ready,
    output logic                                            o_valid,
    output logic [itda_pkg::ITDA_CODE_BITS-1:0]             o_char_code,
    output logic                                            o_last,
    input  logic                                            i_ready
);
    import itda_pkg::*;

    localparam int NDIG = itda_ndig(VALUE_BITS);
    localparam int BW   = 4 * NDIG;
    localparam int LW   = $clog2(NDIG + 1);
    localparam logic [LW-1:0] ONE_LEFT = LW'(1);

    t_emit_state    r_state, n_state;
    logic [BW-1:0]  r_digits;
    logic [LW-1:0]  r_left;
    logic           r_neg;
    logic [3:0]     w_top;
    logic           w_top_zero;
    logic           w_load;
    logic           w_shift;

    assign w_top      = r_digits[BW-1 -: 4];
    assign w_top_zero = (w_top == 4'd0) && (r_left != ONE_LEFT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            E_IDLE: begin
                if (i_ctl.valid) begin
                    n_state = E_SKIP;
                end
            end
            E_SKIP: begin
                if (!w_top_zero) begin
                    n_state = r_neg ? E_SIGN : E_DIGIT;
                end
            end
            E_SIGN: begin
                if (i_ready) begin
                    n_state = E_DIGIT;
                end
            end
            E_DIGIT: begin
                if (i_ready && r_left == ONE_LEFT) begin
                    n_state = E_IDLE;
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        o_valid     = 1'b0;
        o_char_code = ITDA_ASCII_ZERO + {2'b00, w_top};
        o_last      = 1'b0;
        w_load      = 1'b0;
        w_shift     = 1'b0;
        unique case (r_state)
            E_IDLE: begin
                o_ready = 1'b1;
                w_load  = i_ctl.valid;
            end
            E_SKIP: begin
                w_shift = w_top_zero;
            end
            E_SIGN: begin
                o_valid     = 1'b1;
                o_char_code = ITDA_ASCII_MINUS;
            end
            E_DIGIT: begin
                o_valid = 1'b1;
                o_last  = (r_left == ONE_LEFT);
                w_shift = i_ready && (r_left != ONE_LEFT);
            end
            default: o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_digits <= i_bcd;
            r_neg    <= i_ctl.neg;
            r_left   <= LW'(NDIG);
        end else if (w_shift) begin
            r_digits <= {r_digits[BW-5:0], 4'd0};
            r_left   <= r_left - ONE_LEFT;
        end
    end

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == ITDA_ASCII_MINUS) ||
                    (o_char_code >= ITDA_ASCII_ZERO &&
                     o_char_code <= ITDA_ASCII_ZERO + {2'b00, ITDA_RADIX_M1}))
        else $error("illegal character code");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> r_state == E_IDLE)
        else $error("emitter kept running after final character");

    a_sign_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_SIGN) |-> !o_last && r_neg)
        else $error("sign character emitted out of place");

endmodule

// ===== sv/int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// Signed integer to decimal ASCII text, top level.
// Depends on itda_pkg, itda_bin2bcd and itda_emit.
//
// Input channel: i_valid / o_ready, one signed VALUE_BITS-bit i_value per transfer.
// Output channel: o_valid / i_ready, one character per transfer, o_char_code in
// ASCII ('-' then digits, most significant first, no leading zeros), o_last set
// on the final character of each number.
// Timing: the converter shifts one bit of the magnitude per cycle, and it takes
// a new item only after it has handed its result on to the emitter.
// The emitter works on the previous item meanwhile: it drops one leading zero
// digit per cycle, then sends one character per cycle while i_ready is high.
// The first character is offered once the converter has shifted in every bit
// and handed its result on, and the emitter has left its skip state.
// Stall: a stalled receiver holds the current character; the converter then
// finishes and holds its result, and o_ready stays low until it is handed on.
// Reset (synchronous, active low) drops any item in flight and returns both
// parts to idle; no output is pending after reset.
module int_to_decimal_ascii #(
    parameter int VALUE_BITS = itda_pkg::ITDA_VALUE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [VALUE_BITS-1:0]        i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [itda_pkg::ITDA_CODE_BITS-1:0] o_char_code,
    output logic                                o_last
);
    import itda_pkg::*;

    localparam int NDIG = itda_ndig(VALUE_BITS);

    t_bcd_ctl           w_ctl;
    logic [4*NDIG-1:0]  w_bcd;
    logic               w_emit_ready;

    itda_bin2bcd #(
        .VALUE_BITS (VALUE_BITS)
    ) u_bin2bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_ctl   (w_ctl),
        .o_bcd   (w_bcd),
        .i_ready (w_emit_ready)
    );

    itda_emit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_bcd       (w_bcd),
        .o_ready     (w_emit_ready),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .i_ready     (i_ready)
    );

endmodule
